// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/vpm_pkg.sv -----
// Shared types, codes and constants of the visited pixel map engine.
// No dependencies.
package vpm_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam int CFG_W   = 9;
  localparam int ENTRY_W = 3;
  localparam int MASK_W  = 8;

  localparam logic [CFG_W-1:0] SIZE_RST = 9'd256;

  // Register index, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    FN_WRITE = 3'd0,
    FN_READ  = 3'd1,
    FN_SCAN  = 3'd2,
    FN_NBR   = 3'd3,
    FN_CLEAR = 3'd4,
    FN_ANY   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NONE  = 2'd2
  } status_t;

  localparam logic [1:0] MK_UNVISITED = 2'd0;
  localparam logic [1:0] MK_VISITED   = 2'd1;
  localparam logic [1:0] MK_EXCLUDED  = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        found_row;
    logic [7:0]        found_col;
    logic              read_on;
    logic [1:0]        read_state;
    logic [MASK_W-1:0] nbr_mask;
    logic              any_unv;
  } res_t;

  typedef struct packed {
    logic idle;
    logic walking;
  } seq_stat_t;

endpackage

// ----- rtl/core/vpm_pixel_ram.sv -----
// Pixel store: simple dual-port synchronous RAM with registered read data.
// No dependencies.
module vpm_pixel_ram #(
  parameter int AW = 16,
  parameter int DW = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/vpm_seq.sv -----
// Operation sequencer: read-modify-write control of the pixel store.
// Depends on vpm_pkg; drives the ports of vpm_pixel_ram.
module vpm_seq
  import vpm_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int RW = $clog2(MAX_ROWS),
  parameter int CW = $clog2(MAX_COLS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   rows_cfg,
  input  logic [CFG_W-1:0]   cols_cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_col,
  input  logic               in_on,
  input  logic [1:0]         in_vs,
  input  logic               in_incl,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  output logic               mem_we,
  output logic [RW+CW-1:0]   mem_waddr,
  output logic [ENTRY_W-1:0] mem_wdata,
  output logic [RW+CW-1:0]   mem_raddr,
  input  logic [ENTRY_W-1:0] mem_rdata,
  output seq_stat_t          stat
);

  localparam int RCAP = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
  localparam int CCAP = (MAX_COLS > 511) ? 511 : MAX_COLS;
  localparam int MW   = (RW > CW) ? RW : CW;
  localparam int XW   = ((MW > CFG_W) ? MW : CFG_W) + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DISP   = 7'b0000010,
    S_RDWAIT = 7'b0000100,
    S_NB     = 7'b0001000,
    S_NBLAST = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    OFS_DEC  = 2'd0,
    OFS_SAME = 2'd1,
    OFS_INC  = 2'd2
  } ofs_t;

  function automatic ofs_t nb_row_ofs(input logic [2:0] k);
    ofs_t o;
    case (k) inside
      3'd0, 3'd1, 3'd2: o = OFS_DEC;
      3'd3, 3'd4:       o = OFS_SAME;
      default:          o = OFS_INC;
    endcase
    return o;
  endfunction

  function automatic ofs_t nb_col_ofs(input logic [2:0] k);
    ofs_t o;
    case (k) inside
      3'd0, 3'd3, 3'd5: o = OFS_DEC;
      3'd1, 3'd6:       o = OFS_SAME;
      default:          o = OFS_INC;
    endcase
    return o;
  endfunction

  // {in range, coordinate}
  function automatic logic [9:0] nb_coord(input logic [7:0] x, input ofs_t o,
                                          input logic [CFG_W-1:0] lim);
    logic [8:0] y;
    logic       ok;
    y  = {1'b0, x};
    ok = 1'b1;
    case (o)
      OFS_DEC: begin
        ok = (x != 8'd0);
        y  = y - 9'd1;
      end
      OFS_INC: y = y + 9'd1;
      default: y = {1'b0, x};
    endcase
    ok = ok && (y < lim);
    return {ok, y};
  endfunction

  state_t          state_r, state_nxt;
  logic [2:0]      func_r, func_nxt;
  logic [7:0]      row_r, row_nxt;
  logic [7:0]      col_r, col_nxt;
  logic            on_r, on_nxt;
  logic [1:0]      vs_r, vs_nxt;
  logic            incl_r, incl_nxt;
  res_t            res_r, res_nxt;
  logic [2:0]      k_r, k_nxt;
  logic            p_vld_r, p_vld_nxt;
  logic [2:0]      p_k_r, p_k_nxt;
  logic            p_in_r, p_in_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [RW-1:0]   r_cnt_r, r_cnt_nxt;
  logic [CW-1:0]   c_cnt_r, c_cnt_nxt;
  logic            issue_done_r, issue_done_nxt;
  logic [RW-1:0]   p_r_r, p_r_nxt;
  logic [CW-1:0]   p_c_r, p_c_nxt;
  logic            p_last_r, p_last_nxt;

  logic [CFG_W-1:0] nr, nc;
  logic             inside_pt, empty, last_c, last_r;
  logic [9:0]       nb_r, nb_c;
  logic [1:0]       vs_sat;
  logic [1:0]       e_mark;
  logic             e_on, nb_hit;

  assign nr = (rows_cfg > CFG_W'(RCAP)) ? CFG_W'(RCAP) : rows_cfg;
  assign nc = (cols_cfg > CFG_W'(CCAP)) ? CFG_W'(CCAP) : cols_cfg;

  assign inside_pt = ({1'b0, row_r} < nr) && ({1'b0, col_r} < nc);
  assign empty     = (nr == '0) || (nc == '0);
  assign last_c    = (XW'(c_cnt_r) + XW'(1)) == XW'(nc);
  assign last_r    = (XW'(r_cnt_r) + XW'(1)) == XW'(nr);

  assign nb_r = nb_coord(row_r, nb_row_ofs(k_r), nr);
  assign nb_c = nb_coord(col_r, nb_col_ofs(k_r), nc);

  assign vs_sat = (vs_r > MK_EXCLUDED) ? MK_EXCLUDED : vs_r;
  assign e_on   = mem_rdata[0];
  assign e_mark = mem_rdata[2:1];
  assign nb_hit = p_vld_r && p_in_r && e_on && (incl_r || (e_mark != MK_EXCLUDED));

  assign in_ready     = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_RESP);
  assign res          = res_r;
  assign stat.idle    = (state_r == S_IDLE);
  assign stat.walking = (state_r == S_WALK);

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    on_nxt         = on_r;
    vs_nxt         = vs_r;
    incl_nxt       = incl_r;
    res_nxt        = res_r;
    k_nxt          = k_r;
    p_vld_nxt      = 1'b0;
    p_k_nxt        = p_k_r;
    p_in_nxt       = p_in_r;
    mask_nxt       = mask_r;
    r_cnt_nxt      = r_cnt_r;
    c_cnt_nxt      = c_cnt_r;
    issue_done_nxt = issue_done_r;
    p_r_nxt        = p_r_r;
    p_c_nxt        = p_c_r;
    p_last_nxt     = p_last_r;
    mem_we         = 1'b0;
    mem_waddr      = {RW'(row_r), CW'(col_r)};
    mem_wdata      = {vs_sat, on_r};
    mem_raddr      = {r_cnt_r, c_cnt_r};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          row_nxt   = in_row;
          col_nxt   = in_col;
          on_nxt    = in_on;
          vs_nxt    = in_vs;
          incl_nxt  = in_incl;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_nxt        = '0;
        mask_nxt       = '0;
        k_nxt          = '0;
        r_cnt_nxt      = '0;
        c_cnt_nxt      = '0;
        issue_done_nxt = 1'b0;
        p_last_nxt     = 1'b0;
        mem_raddr      = {RW'(row_r), CW'(col_r)};
        state_nxt      = S_RESP;
        case (func_r)
          FN_WRITE: begin
            mem_we = inside_pt;
            if (!inside_pt) res_nxt.status = ST_RANGE;
          end
          FN_READ: begin
            if (inside_pt) state_nxt = S_RDWAIT;
            else res_nxt.status = ST_RANGE;
          end
          FN_NBR: begin
            if (inside_pt) state_nxt = S_NB;
            else res_nxt.status = ST_RANGE;
          end
          FN_SCAN, FN_CLEAR, FN_ANY: begin
            if (!empty) state_nxt = S_WALK;
            else if (func_r == FN_SCAN) res_nxt.status = ST_NONE;
          end
          default: res_nxt = '0;
        endcase
      end

      S_RDWAIT: begin
        res_nxt.read_on    = e_on;
        res_nxt.read_state = e_mark;
        state_nxt          = S_RESP;
      end

      S_NB: begin
        mem_raddr = {RW'(nb_r[8:0]), CW'(nb_c[8:0])};
        p_vld_nxt = 1'b1;
        p_k_nxt   = k_r;
        p_in_nxt  = nb_r[9] && nb_c[9];
        if (nb_hit) mask_nxt = mask_r | (MASK_W'(1) << p_k_r);
        if (k_r == 3'd7) state_nxt = S_NBLAST;
        else k_nxt = k_r + 3'd1;
      end

      S_NBLAST: begin
        res_nxt.nbr_mask = nb_hit ? (mask_r | (MASK_W'(1) << p_k_r)) : mask_r;
        state_nxt        = S_RESP;
      end

      S_WALK: begin
        // issue stage
        if (!issue_done_r) begin
          p_vld_nxt  = 1'b1;
          p_r_nxt    = r_cnt_r;
          p_c_nxt    = c_cnt_r;
          p_last_nxt = last_c && last_r;
          if (last_c) begin
            c_cnt_nxt = '0;
            if (last_r) issue_done_nxt = 1'b1;
            else r_cnt_nxt = r_cnt_r + RW'(1);
          end else begin
            c_cnt_nxt = c_cnt_r + CW'(1);
          end
        end
        // data stage; writes go to the previous entry, never the one being read
        mem_waddr = {p_r_r, p_c_r};
        if (p_vld_r) begin
          case (func_r)
            FN_SCAN: begin
              if (e_mark == MK_UNVISITED) begin
                if (e_on) begin
                  res_nxt.found_row = 8'(p_r_r);
                  res_nxt.found_col = 8'(p_c_r);
                  state_nxt         = S_RESP;
                end else begin
                  mem_we    = 1'b1;
                  mem_wdata = {MK_VISITED, e_on};
                end
              end
            end
            FN_CLEAR: begin
              if (e_mark == MK_EXCLUDED) begin
                mem_we    = 1'b1;
                mem_wdata = {MK_UNVISITED, e_on};
              end
            end
            FN_ANY: begin
              if (e_mark == MK_UNVISITED) begin
                res_nxt.any_unv = 1'b1;
                state_nxt       = S_RESP;
              end
            end
            default: state_nxt = S_RESP;
          endcase
          if (p_last_r && (state_nxt == S_WALK)) begin
            if (func_r == FN_SCAN) res_nxt.status = ST_NONE;
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      p_vld_r      <= 1'b0;
      issue_done_r <= 1'b0;
      p_last_r     <= 1'b0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      p_vld_r      <= p_vld_nxt;
      issue_done_r <= issue_done_nxt;
      p_last_r     <= p_last_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    on_r    <= on_nxt;
    vs_r    <= vs_nxt;
    incl_r  <= incl_nxt;
    res_r   <= res_nxt;
    p_k_r   <= p_k_nxt;
    p_in_r  <= p_in_nxt;
    mask_r  <= mask_nxt;
    r_cnt_r <= r_cnt_nxt;
    c_cnt_r <= c_cnt_nxt;
    p_r_r   <= p_r_nxt;
    p_c_r   <= p_c_nxt;
  end

endmodule

// ----- rtl/core/visited_pixel_map_engine.sv -----
// Visited pixel map engine, top level: config registers, output register, assertions.
// Depends on vpm_pkg, vpm_pixel_ram, vpm_seq and assert_macros.svh.
// Usage: commands enter on the in_ stream (func in tuser, operands in tdata);
// one result beat per command leaves on the out_ stream (status in tuser).
// Image size is set over the APB-style cfg_ port (rows at 0x0, cols at 0x4);
// the user must write it only while the engine is idle, which the block does
// not enforce. One command is worked on at a time. A neighbour query makes
// eight reads of the single memory read port; scan, clear and any-unvisited
// step through the image one pixel per cycle in a pipelined read-modify-write
// walk, and scan and any-unvisited stop at the first hit.
// in_tready rises again the cycle after a result is handed to the output
// register, so a new command is taken while that result waits on out_tready.
// A stalled receiver holds out_tdata/out_tuser; a second result waits inside.
// Reset clears control state and sets both size registers to 256; pixel
// contents are undefined until written, and no clearing pass is run.
`include "assert_macros.svh"

module visited_pixel_map_engine
  import vpm_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] row, [15:8] col, [16] pixel_on, [18:17] visit_state, [19] include_excluded
  input  logic [23:0] in_tdata,
  // [2:0] func
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] found_row, [15:8] found_col, [16] read_on, [18:17] read_state,
  // [26:19] neighbour_mask, [27] any_unvisited
  output logic [31:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;

  logic [CFG_W-1:0]   rows_r, cols_r;
  logic               cfg_wr;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r;
  logic               res_valid, res_ready;
  res_t               res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  seq_stat_t          stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_COLS) ? 32'(cols_r) : 32'(rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIZE_RST;
      cols_r <= SIZE_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ROWS) rows_r <= cfg_pwdata[CFG_W-1:0];
      else cols_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  vpm_pixel_ram #(
    .AW (AW),
    .DW (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vpm_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RW       (RW),
    .CW       (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rows_cfg  (rows_r),
    .cols_cfg  (cols_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_row    (in_tdata[7:0]),
    .in_col    (in_tdata[15:8]),
    .in_on     (in_tdata[16]),
    .in_vs     (in_tdata[18:17]),
    .in_incl   (in_tdata[19]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .stat      (stat)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {4'b0, out_res_r.any_unv, out_res_r.nbr_mask, out_res_r.read_state,
                       out_res_r.read_on, out_res_r.found_col, out_res_r.found_row};

  `ASSERT_NEXT(a_accept_then_busy, in_tvalid && in_tready, !in_tready, "beat accepted while busy")
  `ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid, "result dropped while stalled")
  `ASSERT_IMPL(a_write_when_busy, mem_we, !stat.idle && !in_tready, "store written while idle")
  `ASSERT_IMPL(a_walk_busy, stat.walking, !in_tready && !res_valid, "walk overlaps a beat")
  `ASSERT_IMPL(a_status_code, out_tvalid, out_tuser <= ST_NONE, "bad status code")

endmodule
